### rtl/twbg_pkg.sv
// ----------------------------------------------------------------------------
// twbg_pkg
// Shared types and codes for the tile map window blit generator.
// ----------------------------------------------------------------------------
package twbg_pkg;

  localparam int MAP_CELLS_DEF    = 4096;
  localparam int MAX_WIN_COLS_DEF = 8;
  localparam int MAX_WIN_ROWS_DEF = 8;

  // Request ops
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MAP_W   = 3'd0;
  localparam logic [2:0] REG_MAP_H   = 3'd1;
  localparam logic [2:0] REG_TILE_W  = 3'd2;
  localparam logic [2:0] REG_TILE_H  = 3'd3;
  localparam logic [2:0] REG_IMAGE_W = 3'd4;
  localparam logic [2:0] REG_IMAGE_H = 3'd5;

  // Divider widths: dividend up to tile * tile_w, divisor up to image size
  localparam int DIV_W = 23;
  localparam int DVS_W = 11;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        addr;
    logic [15:0]        value;
    logic signed [11:0] view_x;
    logic signed [11:0] view_y;
    logic [8:0]         sc;
    logic [8:0]         ec;
    logic [8:0]         sr;
    logic [8:0]         er;
    logic               q_ok;
    logic [8:0]         qx;
    logic [8:0]         qy;
  } cmd_t;

endpackage

### rtl/twbg_front.sv
// ----------------------------------------------------------------------------
// twbg_front
// Accepts requests, clamps the draw window, range-checks the query coordinates,
// and queues decoded commands for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module twbg_front import twbg_pkg::*; #(
  parameter int MAX_WIN_COLS = MAX_WIN_COLS_DEF,
  parameter int MAX_WIN_ROWS = MAX_WIN_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [11:0]        cell_addr,
  input  logic [15:0]        cell_value,
  input  logic signed [11:0] view_x,
  input  logic signed [11:0] view_y,
  input  logic signed [9:0]  start_col,
  input  logic signed [9:0]  start_row,
  input  logic signed [9:0]  win_cols,
  input  logic signed [9:0]  win_rows,
  input  logic signed [9:0]  query_x,
  input  logic signed [9:0]  query_y,
  input  logic [8:0]         map_width,
  input  logic [8:0]         map_height,
  output cmd_t               cmd,
  output logic               cmd_valid,
  input  logic               cmd_pop
);

  function automatic logic [8:0] clamp_map(input logic signed [11:0] v,
                                           input logic [8:0] hi);
    logic [8:0] res;
    if (v < 12'sd0) res = 9'd0;
    else if (v > $signed({3'b000, hi})) res = hi;
    else res = v[8:0];
    return res;
  endfunction

  cmd_t               q [2];
  logic               wp;
  logic               rp;
  logic [1:0]         cnt;
  cmd_t               dec;
  logic signed [11:0] w_s;
  logic signed [11:0] h_s;
  logic               push;

  always_comb begin
    w_s = {{2{win_cols[9]}}, win_cols};
    h_s = {{2{win_rows[9]}}, win_rows};
    if (w_s > 12'(MAX_WIN_COLS)) w_s = 12'(MAX_WIN_COLS);
    if (h_s > 12'(MAX_WIN_ROWS)) h_s = 12'(MAX_WIN_ROWS);
    dec.op     = op;
    dec.addr   = cell_addr;
    dec.value  = cell_value;
    dec.view_x = view_x;
    dec.view_y = view_y;
    dec.sc     = clamp_map({{2{start_col[9]}}, start_col}, map_width);
    dec.sr     = clamp_map({{2{start_row[9]}}, start_row}, map_height);
    dec.ec     = clamp_map($signed({3'b000, dec.sc}) + w_s, map_width);
    dec.er     = clamp_map($signed({3'b000, dec.sr}) + h_s, map_height);
    dec.q_ok   = !query_x[9] && !query_y[9] &&
                 ({1'b0, query_x[8:0]} < {1'b0, map_width}) &&
                 ({1'b0, query_y[8:0]} < {1'b0, map_height});
    dec.qx     = query_x[8:0];
    dec.qy     = query_y[8:0];
  end

  assign in_stall  = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  // op 3 is dropped here
  assign push = in_valid && !in_stall &&
                (op == OP_LOAD || op == OP_DRAW || op == OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= dec;
        wp    <= !wp;
      end
      if (cmd_pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

### rtl/twbg_div.sv
// ----------------------------------------------------------------------------
// twbg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twbg_div import twbg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  logic [4:0]       cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   sh;
  logic             ge;

  assign sh = {rem, quo[DIV_W-1]};
  assign ge = (sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(DIV_W);
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
      quo  <= {quo[DIV_W-2:0], ge};
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end

endmodule

### rtl/twbg_back.sv
// ----------------------------------------------------------------------------
// twbg_back
// Holds the tile store and carries out queued commands: loads, queries and
// window scans with atlas offset computation on a shared divider.
// ----------------------------------------------------------------------------
module twbg_back import twbg_pkg::*; #(
  parameter int MAP_CELLS = MAP_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [8:0]         map_width,
  input  logic [6:0]         tile_w,
  input  logic [6:0]         tile_h,
  input  logic [10:0]        image_w,
  input  logic [10:0]        image_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [9:0]         src_x,
  output logic [15:0]        src_y,
  output logic signed [12:0] dst_x,
  output logic signed [12:0] dst_y,
  output logic signed [16:0] tile_id,
  output logic               last
);

  localparam int ADDR_W = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RPA  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ADR  = 4'd4;
  localparam logic [3:0] S_DAT  = 4'd5;
  localparam logic [3:0] S_D1S  = 4'd6;
  localparam logic [3:0] S_D1W  = 4'd7;
  localparam logic [3:0] S_D2S  = 4'd8;
  localparam logic [3:0] S_D2W  = 4'd9;
  localparam logic [3:0] S_SY   = 4'd10;
  localparam logic [3:0] S_PUSH = 4'd11;
  localparam logic [3:0] S_ADV  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;
  localparam logic [3:0] S_QOUT = 4'd14;

  logic [15:0] mem [MAP_CELLS];

  logic [3:0]         st;
  logic               is_draw;
  logic [8:0]         r;
  logic [8:0]         c;
  logic [8:0]         sc;
  logic [8:0]         ec;
  logic [8:0]         er;
  logic signed [11:0] vx;
  logic signed [11:0] vy;
  logic [10:0]        rpa;
  logic [17:0]        prod;
  logic               addr_ok;
  logic [15:0]        rdata;
  logic [15:0]        t;
  logic [22:0]        twp;
  logic [9:0]         sx;
  logic [15:0]        syq;
  logic [15:0]        sy;
  logic signed [16:0] q_tid;

  logic               pend_valid;
  logic [9:0]         pend_sx;
  logic [15:0]        pend_sy;
  logic signed [12:0] pend_dx;
  logic signed [12:0] pend_dy;
  logic [15:0]        pend_t;

  logic [17:0]        addr_full;
  logic [15:0]        v;
  logic [15:0]        tm1;
  logic [22:0]        sy_full;
  logic signed [13:0] dx_wide;
  logic signed [13:0] dy_wide;
  logic signed [12:0] dx_new;
  logic signed [12:0] dy_new;
  logic               out_ok;
  logic               out_set;
  logic               mem_we;

  logic               div_start;
  logic [DIV_W-1:0]   div_a;
  logic [DVS_W-1:0]   div_b;
  logic               div_busy;
  logic [DIV_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rem;

  twbg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign addr_full = prod + {9'd0, c};
  assign v         = addr_ok ? rdata : 16'd0;
  assign tm1       = v - 16'd1;
  assign sy_full   = {7'd0, syq} * {16'd0, tile_h};
  assign dx_wide   = $signed({2'b00, c, 3'b000}) - $signed({{2{vx[11]}}, vx});
  assign dy_wide   = $signed({2'b00, r, 3'b000}) - $signed({{2{vy[11]}}, vy});
  // destination saturates to the 13-bit signed range
  assign dx_new    = (dx_wide > 14'sd4095)  ? 13'sd4095 :
                     (dx_wide < -14'sd4096) ? -13'sd4096 : $signed(dx_wide[12:0]);
  assign dy_new    = (dy_wide > 14'sd4095)  ? 13'sd4095 :
                     (dy_wide < -14'sd4096) ? -13'sd4096 : $signed(dy_wide[12:0]);
  assign out_ok    = !out_valid || !out_stall;
  assign out_set   = out_ok && ((st == S_PUSH && pend_valid) ||
                                (st == S_FIN) || (st == S_QOUT));
  assign cmd_pop   = (st == S_IDLE) && cmd_valid;
  assign mem_we    = cmd_pop && (cmd.op == OP_LOAD) && (int'(cmd.addr) < MAP_CELLS);

  always_comb begin
    div_start = 1'b0;
    div_a     = twp;
    div_b     = image_w;
    unique case (st)
      S_IDLE: begin
        div_start = cmd_pop && (cmd.op == OP_DRAW) && (tile_h != 7'd0);
        div_a     = {12'd0, image_h};
        div_b     = {4'd0, tile_h};
      end
      S_D1S: div_start = (image_w != 11'd0);
      S_D2S: begin
        div_start = (rpa != 11'd0);
        div_a     = {7'd0, t};
        div_b     = rpa;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Tile store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[ADDR_W'(cmd.addr)] <= cmd.value;
    rdata <= mem[addr_full[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_set || (out_valid && out_stall);
      unique case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            vx <= cmd.view_x;
            vy <= cmd.view_y;
            unique case (cmd.op)
              OP_DRAW: begin
                is_draw    <= 1'b1;
                pend_valid <= 1'b0;
                r          <= cmd.sr;
                c          <= cmd.sc;
                sc         <= cmd.sc;
                ec         <= cmd.ec;
                er         <= cmd.er;
                rpa        <= 11'd0;
                st         <= (tile_h != 7'd0) ? S_RPA : S_SCAN;
              end
              OP_QUERY: begin
                is_draw <= 1'b0;
                r       <= cmd.qy;
                c       <= cmd.qx;
                q_tid   <= -17'sd1;
                st      <= cmd.q_ok ? S_MUL : S_QOUT;
              end
              default: st <= S_IDLE;
            endcase
          end
        end
        S_RPA: begin
          if (!div_busy) begin
            rpa <= div_quo[10:0];
            st  <= S_SCAN;
          end
        end
        S_SCAN: st <= (r < er && c < ec) ? S_MUL : S_FIN;
        S_MUL: begin
          prod <= {9'd0, r} * {9'd0, map_width};
          st   <= S_ADR;
        end
        S_ADR: begin
          addr_ok <= (int'(addr_full) < MAP_CELLS);
          st      <= S_DAT;
        end
        S_DAT: begin
          if (!is_draw) begin
            q_tid <= $signed({1'b0, v}) - 17'sd1;
            st    <= S_QOUT;
          end else if (v == 16'd0) begin
            st <= S_ADV;
          end else begin
            t   <= tm1;
            twp <= {7'd0, tm1} * {16'd0, tile_w};
            st  <= S_D1S;
          end
        end
        S_D1S: begin
          if (image_w != 11'd0) begin
            st <= S_D1W;
          end else begin
            sx <= 10'd0;
            st <= S_D2S;
          end
        end
        S_D1W: begin
          if (!div_busy) begin
            sx <= div_rem[9:0];
            st <= S_D2S;
          end
        end
        S_D2S: begin
          if (rpa != 11'd0) begin
            st <= S_D2W;
          end else begin
            sy <= 16'd0;
            st <= S_PUSH;
          end
        end
        S_D2W: begin
          if (!div_busy) begin
            syq <= div_quo[15:0];
            st  <= S_SY;
          end
        end
        S_SY: begin
          sy <= (sy_full > 23'd65535) ? 16'hFFFF : sy_full[15:0];
          st <= S_PUSH;
        end
        S_PUSH: begin
          // one result is held back so the final one can carry last
          if (!pend_valid || out_ok) begin
            if (pend_valid) begin
              kind      <= KIND_DRAW;
              src_x     <= pend_sx;
              src_y     <= pend_sy;
              dst_x     <= pend_dx;
              dst_y     <= pend_dy;
              tile_id   <= $signed({1'b0, pend_t});
              last      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_sx    <= sx;
            pend_sy    <= sy;
            pend_dx    <= dx_new;
            pend_dy    <= dy_new;
            pend_t     <= t;
            st         <= S_ADV;
          end
        end
        S_ADV: begin
          if (c + 9'd1 == ec) begin
            c <= sc;
            r <= r + 9'd1;
          end else begin
            c <= c + 9'd1;
          end
          st <= S_SCAN;
        end
        S_FIN: begin
          if (out_ok) begin
            last       <= 1'b1;
            pend_valid <= 1'b0;
            if (pend_valid) begin
              kind    <= KIND_DRAW;
              src_x   <= pend_sx;
              src_y   <= pend_sy;
              dst_x   <= pend_dx;
              dst_y   <= pend_dy;
              tile_id <= $signed({1'b0, pend_t});
            end else begin
              kind    <= KIND_NONE;
              src_x   <= 10'd0;
              src_y   <= 16'd0;
              dst_x   <= 13'sd0;
              dst_y   <= 13'sd0;
              tile_id <= -17'sd1;
            end
            st <= S_IDLE;
          end
        end
        S_QOUT: begin
          if (out_ok) begin
            kind      <= KIND_QUERY;
            src_x     <= 10'd0;
            src_y     <= 16'd0;
            dst_x     <= 13'sd0;
            dst_y     <= 13'sd0;
            tile_id   <= q_tid;
            last      <= 1'b1;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/tilemap_window_blit_generator_unit.sv
// ----------------------------------------------------------------------------
// tilemap_window_blit_generator_unit
// Tile map store with window draw, cell load and cell query requests.
// ----------------------------------------------------------------------------
// A front end clamps each draw window and queues up to two requests, so requests
// are taken while the back end is still busy. The back end takes one queued
// request at a time. A draw first computes rows per atlas on the divider,
// then scans each window cell; for each non-empty cell, two 23-step
// divisions on the single shared divider dominate the work. Results wait in
// an output register; one draw command is held back until the next one is
// found so the final one is marked last. The tile store has no reset; cells
// must be loaded before use.
module tilemap_window_blit_generator_unit import twbg_pkg::*; #(
  parameter int MAP_CELLS    = MAP_CELLS_DEF,
  parameter int MAX_WIN_COLS = MAX_WIN_COLS_DEF,
  parameter int MAX_WIN_ROWS = MAX_WIN_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [11:0]        cell_addr,
  input  logic [15:0]        cell_value,
  input  logic signed [11:0] view_x,
  input  logic signed [11:0] view_y,
  input  logic signed [9:0]  start_col,
  input  logic signed [9:0]  start_row,
  input  logic signed [9:0]  win_cols,
  input  logic signed [9:0]  win_rows,
  input  logic signed [9:0]  query_x,
  input  logic signed [9:0]  query_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [9:0]         src_x,
  output logic [15:0]        src_y,
  output logic signed [12:0] dst_x,
  output logic signed [12:0] dst_y,
  output logic signed [16:0] tile_id,
  output logic               last
);

  logic [8:0]  map_width;
  logic [8:0]  map_height;
  logic [6:0]  tile_w;
  logic [6:0]  tile_h;
  logic [10:0] image_w;
  logic [10:0] image_h;
  logic        cfg_we;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 9'd0;
      map_height <= 9'd0;
      tile_w     <= 7'd8;
      tile_h     <= 7'd8;
      image_w    <= 11'd64;
      image_h    <= 11'd64;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_MAP_W:   map_width  <= pwdata[8:0];
        REG_MAP_H:   map_height <= pwdata[8:0];
        REG_TILE_W:  tile_w     <= pwdata[6:0];
        REG_TILE_H:  tile_h     <= pwdata[6:0];
        REG_IMAGE_W: image_w    <= pwdata[10:0];
        REG_IMAGE_H: image_h    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MAP_W:   prdata = {23'd0, map_width};
      REG_MAP_H:   prdata = {23'd0, map_height};
      REG_TILE_W:  prdata = {25'd0, tile_w};
      REG_TILE_H:  prdata = {25'd0, tile_h};
      REG_IMAGE_W: prdata = {21'd0, image_w};
      REG_IMAGE_H: prdata = {21'd0, image_h};
      default:     prdata = 32'd0;
    endcase
  end

  twbg_front #(
    .MAX_WIN_COLS (MAX_WIN_COLS),
    .MAX_WIN_ROWS (MAX_WIN_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .cell_addr  (cell_addr),
    .cell_value (cell_value),
    .view_x     (view_x),
    .view_y     (view_y),
    .start_col  (start_col),
    .start_row  (start_row),
    .win_cols   (win_cols),
    .win_rows   (win_rows),
    .query_x    (query_x),
    .query_y    (query_y),
    .map_width  (map_width),
    .map_height (map_height),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  twbg_back #(
    .MAP_CELLS (MAP_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .map_width (map_width),
    .tile_w    (tile_w),
    .tile_h    (tile_h),
    .image_w   (image_w),
    .image_h   (image_h),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .src_x     (src_x),
    .src_y     (src_y),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .tile_id   (tile_id),
    .last      (last)
  );

  a_query_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_QUERY |-> last)
    else $error("query answer without last");

  a_none_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NONE |-> last && tile_id == -17'sd1 && src_x == 10'd0)
    else $error("nothing-drawn result malformed");

  a_draw_tile: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DRAW |-> !tile_id[16])
    else $error("draw command with empty tile");

endmodule
